FILE: hdl/gspt_pkg.sv
package gspt_pkg;

  // item kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_BUILD = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;
  localparam logic [1:0] KIND_SET   = 2'd3;

  // ramp codes
  localparam logic [1:0] RAMP_NONE = 2'd0;
  localparam logic [1:0] RAMP_NS   = 2'd1;
  localparam logic [1:0] RAMP_EW   = 2'd2;
  localparam logic [1:0] RAMP_BAD  = 2'd3;

  // configuration port
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;
  localparam logic [CFG_IW-1:0] CFG_STEP_LIMIT = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_GRID_COLS  = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_GRID_ROWS  = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_ORIGIN_COL = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_ORIGIN_ROW = 3'd4;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] first_col;
    logic signed [15:0] first_row;
    logic signed [15:0] second_col;
    logic signed [15:0] second_row;
    logic signed [15:0] cell_height;
    logic [1:0]         ramp_kind;
    logic               open_edge;
  } in_t;

  typedef struct packed {
    logic       move_allowed;
    logic [1:0] answered_kind;
  } out_t;

  typedef enum logic [1:0] {ER_NONE, ER_QA, ER_PA, ER_PB} erd_sel_e;
  typedef enum logic [2:0] {EW_NONE, EW_FILL, EW_MASK, EW_PA, EW_PB} ewr_sel_e;

  typedef struct packed {
    logic     cap;
    erd_sel_e erd;
    ewr_sel_e ewr;
    logic     load_wr;
    logic     h_rd_cell;
    logic     h_rd_nb;
    logic     h_cap;
    logic     n_cmp;
    logic     dir_inc;
    logic     scan_fill;
    logic     scan_grid;
    logic     scan_next;
    logic     ramp_rd;
    logic     side_tgl;
    logic     pair_item;
    logic     pair_ramp;
    logic     push;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       q_easy;
    logic       set_ok;
    logic       scan_last;
    logic       dir_last;
    logic       nb_ok;
    logic       rk_nb_ok;
    logic       side;
    logic       out_free;
  } sts_t;

  // direction index: NW 0, N 1, NE 2, W 3, E 4, SW 5, S 6, SE 7; opposite is ~idx
  function automatic logic [2:0] dir_idx(input logic signed [1:0] dc,
                                         input logic signed [1:0] dr);
    logic [2:0] n;
    n = 3'd0;
    case ({dr, dc})
      4'b1111: n = 3'd0;
      4'b1100: n = 3'd1;
      4'b1101: n = 3'd2;
      4'b0011: n = 3'd3;
      4'b0001: n = 3'd4;
      4'b0111: n = 3'd5;
      4'b0100: n = 3'd6;
      4'b0101: n = 3'd7;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic signed [1:0] dir_dc(input logic [2:0] idx);
    logic signed [1:0] d;
    case (idx)
      3'd0, 3'd3, 3'd5: d = -2'sd1;
      3'd1, 3'd6:       d = 2'sd0;
      default:          d = 2'sd1;
    endcase
    return d;
  endfunction

  function automatic logic signed [1:0] dir_dr(input logic [2:0] idx);
    logic signed [1:0] d;
    case (idx)
      3'd0, 3'd1, 3'd2: d = -2'sd1;
      3'd3, 3'd4:       d = 2'sd0;
      default:          d = 2'sd1;
    endcase
    return d;
  endfunction

endpackage

FILE: hdl/gspt_ctrl.sv
module gspt_ctrl
  import gspt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_kind_i,
  input  sts_t       sts_i,
  output logic       in_ready_o,
  output cmd_t       cmd_o
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_LOAD, S_QRD, S_QANS, S_SET,
    S_EARD, S_EAWR, S_EBRD, S_EBWR,
    S_FILL, S_H0RD, S_H0CAP, S_NRD, S_NCMP, S_MWR,
    S_RRD, S_RCHK, S_RNEXT, S_DONE
  } state_e;

  state_e state_q, state_d;
  cmd_t   cmd;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    case (state_q)
      S_CLR: begin
        cmd.ewr       = EW_FILL;
        cmd.scan_next = 1'b1;
        if (sts_i.scan_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.cap = 1'b1;
          case (in_kind_i)
            KIND_LOAD:  state_d = S_LOAD;
            KIND_BUILD: begin
              cmd.scan_fill = 1'b1;
              state_d       = S_FILL;
            end
            KIND_QUERY: state_d = S_QRD;
            default:    state_d = S_SET;
          endcase
        end
      end
      S_LOAD: begin
        cmd.load_wr = 1'b1;
        cmd.push    = sts_i.out_free;
        state_d     = sts_i.out_free ? S_IDLE : S_DONE;
      end
      S_QRD: begin
        if (sts_i.q_easy) begin
          cmd.push = sts_i.out_free;
          state_d  = sts_i.out_free ? S_IDLE : S_DONE;
        end else begin
          cmd.erd = ER_QA;
          state_d = S_QANS;
        end
      end
      S_QANS: begin
        cmd.push = sts_i.out_free;
        state_d  = sts_i.out_free ? S_IDLE : S_DONE;
      end
      S_SET: begin
        if (sts_i.set_ok) begin
          cmd.pair_item = 1'b1;
          state_d       = S_EARD;
        end else begin
          cmd.push = sts_i.out_free;
          state_d  = sts_i.out_free ? S_IDLE : S_DONE;
        end
      end
      S_EARD: begin
        cmd.erd = ER_PA;
        state_d = S_EAWR;
      end
      S_EAWR: begin
        cmd.ewr = EW_PA;
        state_d = S_EBRD;
      end
      S_EBRD: begin
        cmd.erd = ER_PB;
        state_d = S_EBWR;
      end
      S_EBWR: begin
        cmd.ewr = EW_PB;
        if (sts_i.kind == KIND_SET) begin
          cmd.push = sts_i.out_free;
          state_d  = sts_i.out_free ? S_IDLE : S_DONE;
        end else begin
          state_d = S_RNEXT;
        end
      end
      S_FILL: begin
        cmd.ewr = EW_FILL;
        if (sts_i.scan_last) begin
          cmd.scan_grid = 1'b1;
          state_d       = S_H0RD;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_H0RD: begin
        cmd.h_rd_cell = 1'b1;
        state_d       = S_H0CAP;
      end
      S_H0CAP: begin
        cmd.h_cap = 1'b1;
        state_d   = S_NRD;
      end
      S_NRD: begin
        if (sts_i.nb_ok) begin
          cmd.h_rd_nb = 1'b1;
          state_d     = S_NCMP;
        end else if (sts_i.dir_last) begin
          state_d = S_MWR;
        end else begin
          cmd.dir_inc = 1'b1;
        end
      end
      S_NCMP: begin
        cmd.n_cmp = 1'b1;
        if (sts_i.dir_last) begin
          state_d = S_MWR;
        end else begin
          cmd.dir_inc = 1'b1;
          state_d     = S_NRD;
        end
      end
      S_MWR: begin
        cmd.ewr = EW_MASK;
        if (sts_i.scan_last) begin
          cmd.scan_grid = 1'b1;
          state_d       = S_RRD;
        end else begin
          cmd.scan_next = 1'b1;
          state_d       = S_H0RD;
        end
      end
      S_RRD: begin
        cmd.ramp_rd = 1'b1;
        state_d     = S_RCHK;
      end
      S_RCHK: begin
        if (sts_i.rk_nb_ok) begin
          cmd.pair_ramp = 1'b1;
          state_d       = S_EARD;
        end else begin
          state_d = S_RNEXT;
        end
      end
      S_RNEXT: begin
        if (!sts_i.side) begin
          cmd.side_tgl = 1'b1;
          state_d      = S_RCHK;
        end else if (sts_i.scan_last) begin
          cmd.push = sts_i.out_free;
          state_d  = sts_i.out_free ? S_IDLE : S_DONE;
        end else begin
          cmd.scan_next = 1'b1;
          state_d       = S_RRD;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd.push = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o      = cmd;

endmodule

FILE: hdl/gspt_dp.sv
module gspt_dp
  import gspt_pkg::*;
#(
  parameter int MAX_COLS    = 64,
  parameter int MAX_ROWS    = 64,
  parameter int HEIGHT_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  input  in_t               in_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output out_t              out_o
);

  localparam int CELLS = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int XW    = $clog2(MAX_COLS);
  localparam int YW    = $clog2(MAX_ROWS);
  localparam int CNW   = $clog2(MAX_COLS + 1);
  localparam int RNW   = $clog2(MAX_ROWS + 1);
  localparam int LW    = 18;
  localparam int HB    = HEIGHT_BITS;
  localparam int DW    = (HB + 1 > 16) ? HB + 1 : 16;

  function automatic logic in_g(input logic signed [LW-1:0] c,
                                input logic signed [LW-1:0] r,
                                input logic [CNW-1:0] nc,
                                input logic [RNW-1:0] nr);
    return !c[LW-1] && !r[LW-1] && ($unsigned(c) < LW'(nc)) && ($unsigned(r) < LW'(nr));
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic signed [LW-1:0] c,
                                            input logic signed [LW-1:0] r);
    return AW'(AW'(r) * AW'(MAX_COLS) + AW'(c));
  endfunction

  // configuration
  logic [15:0]        step_q;
  logic [6:0]         cols_q, rows_q;
  logic signed [15:0] ocol_q, orow_q;
  logic [CNW-1:0]     ncol;
  logic [RNW-1:0]     nrow;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 16'd1;
      cols_q <= 7'd64;
      rows_q <= 7'd64;
      ocol_q <= '0;
      orow_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STEP_LIMIT: step_q <= cfg_wdata_i;
        CFG_GRID_COLS:  cols_q <= cfg_wdata_i[6:0];
        CFG_GRID_ROWS:  rows_q <= cfg_wdata_i[6:0];
        CFG_ORIGIN_COL: ocol_q <= $signed(cfg_wdata_i);
        CFG_ORIGIN_ROW: orow_q <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cols_q == '0) ncol = CNW'(1);
    else if (32'(cols_q) > 32'(MAX_COLS)) ncol = CNW'(MAX_COLS);
    else ncol = CNW'(cols_q);
    if (rows_q == '0) nrow = RNW'(1);
    else if (32'(rows_q) > 32'(MAX_ROWS)) nrow = RNW'(MAX_ROWS);
    else nrow = RNW'(rows_q);
  end

  // captured item and its local coordinates
  in_t item_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) item_q <= in_i;
  end

  logic signed [LW-1:0] ca, ra, cb, rb, dcw, drw;
  logic ina, inb, zero, unit;
  logic [2:0] qbit;

  always_comb begin
    ca   = LW'(item_q.first_col) - LW'(ocol_q);
    ra   = LW'(item_q.first_row) - LW'(orow_q);
    cb   = LW'(item_q.second_col) - LW'(ocol_q);
    rb   = LW'(item_q.second_row) - LW'(orow_q);
    dcw  = LW'(item_q.second_col) - LW'(item_q.first_col);
    drw  = LW'(item_q.second_row) - LW'(item_q.first_row);
    ina  = in_g(ca, ra, ncol, nrow);
    inb  = in_g(cb, rb, ncol, nrow);
    zero = (dcw == '0) && (drw == '0);
    unit = ((dcw == '0) || (dcw == LW'(1)) || (dcw == '1)) &&
           ((drw == '0) || (drw == LW'(1)) || (drw == '1));
    qbit = dir_idx(dcw[1:0], drw[1:0]);
  end

  // cell scan
  logic [XW-1:0] scol_q, lastc;
  logic [YW-1:0] srow_q, lastr;
  logic          sfull_q, scan_last;
  logic [AW-1:0] saddr;
  logic signed [LW-1:0] sc, sr;

  assign lastc     = sfull_q ? XW'(MAX_COLS - 1) : XW'(ncol - CNW'(1));
  assign lastr     = sfull_q ? YW'(MAX_ROWS - 1) : YW'(nrow - RNW'(1));
  assign scan_last = (scol_q == lastc) && (srow_q == lastr);
  assign saddr     = AW'(AW'(srow_q) * AW'(MAX_COLS) + AW'(scol_q));
  assign sc        = $signed(LW'(scol_q));
  assign sr        = $signed(LW'(srow_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scol_q  <= '0;
      srow_q  <= '0;
      sfull_q <= 1'b1;
    end else if (cmd_i.scan_fill || cmd_i.scan_grid) begin
      scol_q  <= '0;
      srow_q  <= '0;
      sfull_q <= cmd_i.scan_fill;
    end else if (cmd_i.scan_next) begin
      if (scol_q == lastc) begin
        scol_q <= '0;
        srow_q <= srow_q + YW'(1);
      end else begin
        scol_q <= scol_q + XW'(1);
      end
    end
  end

  // neighbor walk for the height pass
  logic [2:0]           dir_q;
  logic [7:0]           mask_q;
  logic signed [LW-1:0] nbc, nbr;
  logic                 nb_ok;
  logic signed [HB-1:0] h0_q, hrd_q;
  logic signed [HB:0]   hdiff;
  logic [HB:0]          habs;
  logic                 too_steep;

  assign nbc       = sc + LW'(dir_dc(dir_q));
  assign nbr       = sr + LW'(dir_dr(dir_q));
  assign nb_ok     = in_g(nbc, nbr, ncol, nrow);
  assign hdiff     = (HB + 1)'(h0_q) - (HB + 1)'(hrd_q);
  assign habs      = hdiff[HB] ? $unsigned(-hdiff) : $unsigned(hdiff);
  assign too_steep = DW'(habs) > DW'(step_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.h_cap) begin
      h0_q   <= hrd_q;
      mask_q <= 8'hFF;
      dir_q  <= 3'd0;
    end else begin
      if (cmd_i.n_cmp && too_steep) mask_q[dir_q] <= 1'b0;
      if (cmd_i.dir_inc) dir_q <= dir_q + 3'd1;
    end
  end

  // ramp pass
  logic [1:0]           rrd_q;
  logic                 side_q, ramp_any;
  logic signed [1:0]    rdc, rdr;
  logic signed [LW-1:0] rnc, rnr;

  always_comb begin
    ramp_any = (rrd_q == RAMP_NS) || (rrd_q == RAMP_EW);
    rdc = 2'sd0;
    rdr = 2'sd0;
    case (rrd_q)
      RAMP_NS: rdr = -2'sd1;
      RAMP_EW: rdc = 2'sd1;
      default: ;
    endcase
    if (side_q) begin
      rdc = -rdc;
      rdr = -rdr;
    end
    rnc = sc + LW'(rdc);
    rnr = sr + LW'(rdr);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ramp_rd) side_q <= 1'b0;
    else if (cmd_i.side_tgl) side_q <= ~side_q;
  end

  // edge pair for read-modify-write
  logic [AW-1:0] pa_q, pb_q;
  logic [2:0]    pbit_q;
  logic          popen_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pair_item) begin
      pa_q    <= addr_of(ca, ra);
      pb_q    <= addr_of(cb, rb);
      pbit_q  <= qbit;
      popen_q <= item_q.open_edge;
    end else if (cmd_i.pair_ramp) begin
      pa_q    <= saddr;
      pb_q    <= addr_of(rnc, rnr);
      pbit_q  <= dir_idx(rdc, rdr);
      popen_q <= 1'b1;
    end
  end

  // memories
  logic [7:0]    emem [CELLS];
  logic [HB-1:0] hmem [CELLS];
  logic [1:0]    rmem [CELLS];
  logic [7:0]    erd_q, ewd, bit_a, bit_b;
  logic [AW-1:0] ewa, era, hra, lda;
  logic          ewe, ere, hre, lde;

  assign bit_a = 8'd1 << pbit_q;
  assign bit_b = 8'd1 << (~pbit_q);
  assign lda   = addr_of(ca, ra);
  assign lde   = cmd_i.load_wr && ina;
  assign hre   = cmd_i.h_rd_cell || cmd_i.h_rd_nb;
  assign hra   = cmd_i.h_rd_nb ? addr_of(nbc, nbr) : saddr;

  always_comb begin
    ewe = 1'b1;
    ewa = saddr;
    ewd = 8'hFF;
    case (cmd_i.ewr)
      EW_FILL: ewd = 8'hFF;
      EW_MASK: ewd = mask_q;
      EW_PA: begin
        ewa = pa_q;
        ewd = popen_q ? (erd_q | bit_a) : (erd_q & ~bit_a);
      end
      EW_PB: begin
        ewa = pb_q;
        ewd = popen_q ? (erd_q | bit_b) : (erd_q & ~bit_b);
      end
      default: ewe = 1'b0;
    endcase
    ere = 1'b1;
    case (cmd_i.erd)
      ER_QA:   era = lda;
      ER_PA:   era = pa_q;
      ER_PB:   era = pb_q;
      default: begin
        era = pa_q;
        ere = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ewe) emem[ewa] <= ewd;
    if (ere) erd_q <= emem[era];
  end

  always_ff @(posedge clk_i) begin
    if (lde) hmem[lda] <= HB'(item_q.cell_height);
    if (hre) hrd_q <= $signed(hmem[hra]);
  end

  always_ff @(posedge clk_i) begin
    if (lde) rmem[lda] <= (item_q.ramp_kind == RAMP_BAD) ? RAMP_NONE : item_q.ramp_kind;
    if (cmd_i.ramp_rd) rrd_q <= rmem[saddr];
  end

  // result register
  logic ov_q, allowed;
  out_t out_q;

  assign allowed = (item_q.kind == KIND_QUERY) &&
                   ((!ina || !inb || zero) || (unit && erd_q[qbit]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.push) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_q.move_allowed  <= allowed;
      out_q.answered_kind <= item_q.kind;
    end
  end

  assign out_valid_o = ov_q;
  assign out_o       = out_q;

  always_comb begin
    sts_o.kind      = item_q.kind;
    sts_o.q_easy    = !ina || !inb || zero || !unit;
    sts_o.set_ok    = ina && inb && unit && !zero;
    sts_o.scan_last = scan_last;
    sts_o.dir_last  = (dir_q == 3'd7);
    sts_o.nb_ok     = nb_ok;
    sts_o.rk_nb_ok  = ramp_any && in_g(rnc, rnr, ncol, nrow);
    sts_o.side      = side_q;
    sts_o.out_free  = !ov_q || out_ready_i;
  end

endmodule

FILE: hdl/grid_step_passability_table_top.sv
// grid step passability table
// input channel: in_valid_i / in_ready_o carry one item (load cell, build masks,
//   query move, set edge); a transfer happens when both are high
// output channel: out_valid_o / out_ready_i carry exactly one result per item,
//   move_allowed for queries (zero otherwise) and the echoed kind
// config port: cfg_we_i writes cfg_wdata_i to register cfg_idx_i, to be done
//   only while the block is idle; the block itself does not enforce this
// steps per item: a load writes the height and ramp memories; a query that
//   needs the mask reads the edge memory; a valid set edge read-modify-writes
//   both cells' masks; build: a fill pass over all MAX_COLS*MAX_ROWS cells,
//   then a height pass over the grid cells and a ramp pass reopening ramp edges
// one item is in work at a time; ready is high only between items
// reset: configuration goes to its defaults, then a clearing pass over all
//   MAX_COLS*MAX_ROWS cells opens every edge mask before the first transfer
// heights and ramps are undefined until loaded
// a stalled receiver holds the result in the output register; the next item
//   is still taken and its result waits until that register frees up
module grid_step_passability_table_top
  import gspt_pkg::*;
#(
  parameter int MAX_COLS    = 64,
  parameter int MAX_ROWS    = 64,
  parameter int HEIGHT_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_t               in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_t              out_o
);

  // commands from the sequencer, status back from the datapath
  cmd_t cmd;
  sts_t sts;

  gspt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_i.kind),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  // memories, scan counters, config registers and the result register
  gspt_dp #(
    .MAX_COLS    (MAX_COLS),
    .MAX_ROWS    (MAX_ROWS),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

endmodule

FILE: dv/grid_step_passability_table_top_tb.sv
module grid_step_passability_table_top_tb;
  import gspt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCOLS = 64;
  localparam int NROWS = 64;
  localparam int NCELLS = NCOLS * NROWS;
  // idle watchdog limit, sized to cover a build at full size
  localparam int STALL_LIMIT = 400000;
  localparam int HOLD_CYCLES = 200;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CFG_IW-1:0] cfg_idx_i;
  logic [CFG_DW-1:0] cfg_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  in_t               in_i;
  logic              out_valid_o;
  logic              out_ready_i;
  out_t              out_o;

  grid_step_passability_table_top dut (.*);

  // clock: 10 ns period
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // mirror of the block state used by the predictor
  logic [15:0]        pass_limit;
  int                 used_cols;
  int                 used_rows;
  int                 org_col;
  int                 org_row;
  logic [7:0]         mask_mem [NCELLS];
  logic signed [15:0] height_mem [NCELLS];
  logic [1:0]         ramp_mem [NCELLS];
  bit                 loaded [NCELLS];

  out_t expected_answers[$];
  int   errors;
  int   answers_seen;
  int   items_sent;
  int   queries_sent;
  int   builds_sent;
  int   idle_cycles;
  int   hold_cnt;
  int   rx_idle_left;
  bit   rx_stall_en;
  bit   tx_stall_en;
  bit   hold_rx;

  function automatic bit on_grid(int c, int r);
    return c >= 0 && r >= 0 && c < used_cols && r < used_rows;
  endfunction

  function automatic int cell_addr(int c, int r);
    return r * NCOLS + c;
  endfunction

  function automatic logic [7:0] bit_for(int dc, int dr);
    int n;
    n = (dr + 1) * 3 + (dc + 1);
    if (n > 4) n--;
    return 8'd1 << n;
  endfunction

  function automatic void edge_write(int ca, int ra, int cb, int rb, bit op);
    int dc;
    int dr;
    dc = cb - ca;
    dr = rb - ra;
    if (!on_grid(ca, ra) || !on_grid(cb, rb)) return;
    if (dc > 1 || dc < -1 || dr > 1 || dr < -1 || (dc == 0 && dr == 0)) return;
    if (op) begin
      mask_mem[cell_addr(ca, ra)] |= bit_for(dc, dr);
      mask_mem[cell_addr(cb, rb)] |= bit_for(-dc, -dr);
    end else begin
      mask_mem[cell_addr(ca, ra)] &= ~bit_for(dc, dr);
      mask_mem[cell_addr(cb, rb)] &= ~bit_for(-dc, -dr);
    end
  endfunction

  function automatic void rebuild_masks();
    int d;
    int a;
    for (int i = 0; i < NCELLS; i++) mask_mem[i] = 8'hFF;
    for (int r = 0; r < used_rows; r++)
      for (int c = 0; c < used_cols; c++) begin
        a = cell_addr(c, r);
        if (!loaded[a]) begin
          $display("%0t: build reads cell %0d %0d that was never loaded", $time, c, r);
          errors++;
        end
        for (int dr = -1; dr <= 1; dr++)
          for (int dc = -1; dc <= 1; dc++) begin
            if ((dc == 0 && dr == 0) || !on_grid(c + dc, r + dr)) continue;
            d = int'(height_mem[a]) - int'(height_mem[cell_addr(c + dc, r + dr)]);
            if (d < 0) d = -d;
            if (d > int'(pass_limit)) mask_mem[a] &= ~bit_for(dc, dr);
          end
      end
    // ramps reopen along their axis
    for (int r = 0; r < used_rows; r++)
      for (int c = 0; c < used_cols; c++) begin
        if (ramp_mem[cell_addr(c, r)] == RAMP_NS) begin
          edge_write(c, r, c, r - 1, 1'b1);
          edge_write(c, r, c, r + 1, 1'b1);
        end else if (ramp_mem[cell_addr(c, r)] == RAMP_EW) begin
          edge_write(c, r, c + 1, r, 1'b1);
          edge_write(c, r, c - 1, r, 1'b1);
        end
      end
  endfunction

  // predicts the result of one item and updates the mirror
  function automatic out_t passability_predict(in_t it);
    out_t o;
    int c1;
    int r1;
    int c2;
    int r2;
    int dc;
    int dr;
    c1 = int'(it.first_col) - org_col;
    r1 = int'(it.first_row) - org_row;
    c2 = int'(it.second_col) - org_col;
    r2 = int'(it.second_row) - org_row;
    o.move_allowed = 1'b0;
    o.answered_kind = it.kind;
    case (it.kind)
      KIND_LOAD: begin
        if (on_grid(c1, r1)) begin
          height_mem[cell_addr(c1, r1)] = it.cell_height;
          ramp_mem[cell_addr(c1, r1)] = (it.ramp_kind == RAMP_BAD) ? RAMP_NONE : it.ramp_kind;
          loaded[cell_addr(c1, r1)] = 1'b1;
        end
      end
      KIND_BUILD: rebuild_masks();
      KIND_QUERY: begin
        dc = c2 - c1;
        dr = r2 - r1;
        if (!on_grid(c1, r1) || !on_grid(c2, r2) || (dc == 0 && dr == 0))
          o.move_allowed = 1'b1;
        else if (dc > 1 || dc < -1 || dr > 1 || dr < -1)
          o.move_allowed = 1'b0;
        else
          o.move_allowed = (mask_mem[cell_addr(c1, r1)] & bit_for(dc, dr)) != 0;
      end
      default: edge_write(c1, r1, c2, r2, it.open_edge);
    endcase
    return o;
  endfunction

  // sends one item, with optional idle burst before it; valid stays high
  // after the transfer until the next item or an idle stretch replaces it
  task automatic send_item(in_t it);
    if (tx_stall_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_answers.push_back(passability_predict(it));
    items_sent++;
    if (it.kind == KIND_QUERY) queries_sent++;
    if (it.kind == KIND_BUILD) builds_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_STEP_LIMIT: pass_limit = val;
      CFG_GRID_COLS: used_cols = (val[6:0] < 1) ? 1 : (val[6:0] > NCOLS ? NCOLS : val[6:0]);
      CFG_GRID_ROWS: used_rows = (val[6:0] < 1) ? 1 : (val[6:0] > NROWS ? NROWS : val[6:0]);
      CFG_ORIGIN_COL: org_col = int'($signed(val));
      default: org_row = int'($signed(val));
    endcase
    @(posedge clk_i);
  endtask

  function automatic in_t blank_item(logic [1:0] k);
    in_t it;
    it = '0;
    it.kind = k;
    return it;
  endfunction

  function automatic in_t load_item(int gc, int gr, int h, logic [1:0] rk);
    in_t it;
    it = blank_item(KIND_LOAD);
    it.first_col = 16'(gc);
    it.first_row = 16'(gr);
    it.cell_height = 16'(h);
    it.ramp_kind = rk;
    it.second_col = 16'($urandom);
    it.second_row = 16'($urandom);
    it.open_edge = 1'($urandom);
    return it;
  endfunction

  function automatic in_t move_item(logic [1:0] k, int c1, int r1, int c2, int r2, bit op);
    in_t it;
    it = blank_item(k);
    it.first_col = 16'(c1);
    it.first_row = 16'(r1);
    it.second_col = 16'(c2);
    it.second_row = 16'(r2);
    it.open_edge = op;
    it.cell_height = 16'($urandom);
    it.ramp_kind = 2'($urandom);
    return it;
  endfunction

  // loads every in-use cell with random height and ramp, so builds read known data
  task automatic fill_grid(int hspan);
    for (int r = 0; r < used_rows; r++)
      for (int c = 0; c < used_cols; c++)
        send_item(load_item(c + org_col, r + org_row,
                            $urandom_range(0, hspan) - hspan / 2, 2'($urandom)));
  endtask

  // random neighbor-biased move, ends sometimes outside the window
  function automatic in_t rand_move(logic [1:0] k);
    int c1;
    int r1;
    c1 = $urandom_range(0, used_cols) + org_col - ($urandom_range(0, 9) == 0);
    r1 = $urandom_range(0, used_rows) + org_row - ($urandom_range(0, 9) == 0);
    if ($urandom_range(0, 9) == 0)
      return move_item(k, int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                       int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                       1'($urandom));
    return move_item(k, c1, r1, c1 + $urandom_range(0, 4) - 2,
                     r1 + $urandom_range(0, 4) - 2, 1'($urandom));
  endfunction

  // reset-state queries, field extremes, every kind, each special case
  task automatic test_directed();
    send_item(move_item(KIND_QUERY, 0, 0, 1, 1, 1'b0));
    send_item(move_item(KIND_QUERY, 5, 5, 5, 5, 1'b0));
    send_item(move_item(KIND_QUERY, 5, 5, 7, 5, 1'b0));
    send_item(move_item(KIND_QUERY, -32768, 32767, 32767, -32768, 1'b1));
    send_item(move_item(KIND_SET, 3, 3, 4, 4, 1'b0));
    send_item(move_item(KIND_QUERY, 4, 4, 3, 3, 1'b0));
    send_item(move_item(KIND_SET, 3, 3, 3, 3, 1'b0));
    send_item(move_item(KIND_SET, 3, 3, 5, 3, 1'b0));
    send_item(move_item(KIND_SET, -1, 0, 0, 0, 1'b0));
    send_item(move_item(KIND_SET, 4, 4, 3, 3, 1'b1));
    send_item(move_item(KIND_QUERY, 3, 3, 4, 4, 1'b0));
    send_item(load_item(-32768, 32767, 32767, RAMP_BAD));
    send_item(load_item(64, 0, -32768, RAMP_NS));
    drain();
    write_reg(CFG_GRID_COLS, 16'd3);
    write_reg(CFG_GRID_ROWS, 16'd2);
    write_reg(CFG_STEP_LIMIT, 16'd0);
    send_item(load_item(0, 0, 32767, RAMP_NONE));
    send_item(load_item(1, 0, -32768, RAMP_EW));
    send_item(load_item(2, 0, 0, RAMP_BAD));
    send_item(load_item(0, 1, 1, RAMP_NS));
    send_item(load_item(1, 1, 0, RAMP_NONE));
    send_item(load_item(2, 1, 0, RAMP_NONE));
    send_item(blank_item(KIND_BUILD));
    for (int i = 0; i < 8; i++)
      send_item(move_item(KIND_QUERY, 1, 0, i % 3, i / 3 % 2, 1'b0));
    send_item(move_item(KIND_QUERY, 2, 1, 3, 1, 1'b0));
    drain();
  endtask

  // random phase under one setting; the grid is loaded first
  task automatic test_random_phase(int n, int hspan);
    int k;
    fill_grid(hspan);
    send_item(blank_item(KIND_BUILD));
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 15)
        send_item(load_item($urandom_range(0, used_cols + 1) + org_col - 1,
                            $urandom_range(0, used_rows + 1) + org_row - 1,
                            $urandom_range(0, hspan) - hspan / 2, 2'($urandom)));
      else if (k < 17 && used_cols * used_rows <= 64)
        send_item(blank_item(KIND_BUILD));
      else if (k < 75) send_item(rand_move(KIND_QUERY));
      else send_item(rand_move(KIND_SET));
    end
    drain();
  endtask

  // receiver holds off for a long stretch while the sender keeps going
  task automatic test_backpressure();
    hold_rx = 1'b1;
    for (int i = 0; i < 20; i++) send_item(rand_move(KIND_QUERY));
    hold_rx = 1'b0;
    drain();
  endtask

  // receiver side: random idle bursts, long hold-off counted here
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_cnt <= 0;
      rx_idle_left <= 0;
    end else begin
      if (!hold_rx) hold_cnt <= 0;
      else if (hold_cnt < HOLD_CYCLES) hold_cnt <= hold_cnt + 1;
      if (hold_rx && hold_cnt < HOLD_CYCLES) begin
        out_ready_i <= 1'b0;
      end else if (rx_stall_en && rx_idle_left > 0) begin
        out_ready_i <= 1'b0;
        rx_idle_left <= rx_idle_left - 1;
      end else if (rx_stall_en && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        rx_idle_left <= $urandom_range(0, 2);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // checker: compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      answers_seen++;
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result kind %0d allowed %0d", $time,
                 out_o.answered_kind, out_o.move_allowed);
        errors++;
      end else begin
        if (out_o.answered_kind !== expected_answers[0].answered_kind) begin
          $display("%0t: answered_kind expected %0d actual %0d", $time,
                   expected_answers[0].answered_kind, out_o.answered_kind);
          errors++;
        end
        if (out_o.move_allowed !== expected_answers[0].move_allowed) begin
          $display("%0t: move_allowed expected %0d actual %0d", $time,
                   expected_answers[0].move_allowed, out_o.move_allowed);
          errors++;
        end
        void'(expected_answers.pop_front());
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT + 20000) begin
      $display("[grid_step_passability_table_top] ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_STEP_LIMIT;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    in_i = '0;
    errors = 0;
    answers_seen = 0;
    items_sent = 0;
    queries_sent = 0;
    builds_sent = 0;
    idle_cycles = 0;
    hold_rx = 1'b0;
    rx_stall_en = 1'b1;
    tx_stall_en = 1'b1;
    pass_limit = 16'd1;
    used_cols = NCOLS;
    used_rows = NROWS;
    org_col = 0;
    org_row = 0;
    for (int i = 0; i < NCELLS; i++) begin
      mask_mem[i] = 8'hFF;
      loaded[i] = 1'b0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    // small grid, negative origin, tight limit
    write_reg(CFG_ORIGIN_COL, 16'h8000);
    write_reg(CFG_ORIGIN_ROW, 16'hFFFE);
    write_reg(CFG_GRID_COLS, 16'd6);
    write_reg(CFG_GRID_ROWS, 16'd5);
    write_reg(CFG_STEP_LIMIT, 16'd2);
    test_random_phase(300, 8);
    // out-of-range sizes clamp, widest limit, column origin at the top of the range
    write_reg(CFG_ORIGIN_COL, 16'h7FC0);
    write_reg(CFG_ORIGIN_ROW, 16'd100);
    write_reg(CFG_GRID_COLS, 16'h007F);
    write_reg(CFG_GRID_ROWS, 16'h0000);
    write_reg(CFG_STEP_LIMIT, 16'hFFFF);
    test_random_phase(200, 65535);
    // full width grid with one build
    write_reg(CFG_ORIGIN_COL, 16'd0);
    write_reg(CFG_ORIGIN_ROW, 16'd0);
    write_reg(CFG_GRID_COLS, 16'd64);
    write_reg(CFG_GRID_ROWS, 16'd4);
    write_reg(CFG_STEP_LIMIT, 16'd1);
    fill_grid(4);
    send_item(blank_item(KIND_BUILD));
    for (int i = 0; i < 150; i++) send_item(rand_move(KIND_QUERY));
    drain();
    // last part: no idling on either side
    write_reg(CFG_GRID_COLS, 16'd8);
    write_reg(CFG_GRID_ROWS, 16'd4);
    write_reg(CFG_STEP_LIMIT, 16'd3);
    rx_stall_en = 1'b0;
    tx_stall_en = 1'b0;
    test_random_phase(250, 12);
    drain();
    $display("covered %0d items (%0d queries, %0d builds), %0d results checked",
             items_sent, queries_sent, builds_sent, answers_seen);
    $display("configs: small, clamped, full-width and unstalled grids with back-pressure");
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("[grid_step_passability_table_top] OK");
    end else begin
      $display("[grid_step_passability_table_top] ERROR");
    end
    $finish;
  end

endmodule
